FILE: src/cosine_similarity_stream_assert.svh
// Assertion macros for the checker file of this block.
`ifndef COSINE_SIMILARITY_STREAM_ASSERT_SVH
`define COSINE_SIMILARITY_STREAM_ASSERT_SVH

// Checks a property on every rising clock edge outside of reset.
`define COSIM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checks a property on every rising clock edge, reset included.
`define COSIM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: src/cosim_pkg.sv
package cosim_pkg;

  localparam int DOT_W = 42;
  localparam int SQ_W = 41;
  localparam int ROOT_W = 21;
  localparam int FRAC_W = 15;
  localparam int SIM_W = 16;
  localparam int QUOT_W = 18;
  localparam int DIV_W = 60;
  localparam int DCNT_W = 5;

  typedef logic [1:0] status_t;

  localparam status_t STAT_OK = 2'd0;
  localparam status_t STAT_ZERO_NORM = 2'd1;
  localparam status_t STAT_OVERLENGTH = 2'd2;

endpackage

FILE: src/cosine_similarity_stream.sv
// Cosine similarity of two streamed vectors in signed Q1.15. Each request carries one element
// pair; the request marked last closes the vectors and yields one result, similarity in Q1.15
// plus a status (ok, zero norm, or more than MAX_LEN pairs). A single registered multiplier and
// add/compare logic do all the work under a small sequencer. An accumulated pair makes three
// passes through the multiplier and the accumulate before the next pair is taken. A last pair
// then goes through two 21-step bit-pair square roots, one multiply of the roots and an 18-step
// restoring divide, which is skipped on a zero norm or an overflow. A pair beyond MAX_LEN is not
// accumulated and the block stays ready for the next pair, or goes to the result when it closes
// the vectors. A finished result waits in the output register while the next vectors stream in.
module cosine_similarity_stream #(
  parameter int MAX_LEN = 1024,
  parameter int ELEM_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [ELEM_WIDTH-1:0]  elem_a,
  input  logic signed [ELEM_WIDTH-1:0]  elem_b,
  input  logic                          last,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [15:0]            similarity,
  output cosim_pkg::status_t            status
);
  import cosim_pkg::*;

  localparam int MW = (ELEM_WIDTH > ROOT_W + 1) ? ELEM_WIDTH : ROOT_W + 1;
  localparam int CW = $clog2(MAX_LEN + 1);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_MAC_AB   = 4'd1;
  localparam logic [3:0] S_MAC_AA   = 4'd2;
  localparam logic [3:0] S_MAC_BB   = 4'd3;
  localparam logic [3:0] S_MAC_END  = 4'd4;
  localparam logic [3:0] S_ROOT_A   = 4'd5;
  localparam logic [3:0] S_ROOT_B   = 4'd6;
  localparam logic [3:0] S_MUL_R    = 4'd7;
  localparam logic [3:0] S_DIV_LOAD = 4'd8;
  localparam logic [3:0] S_DIV      = 4'd9;
  localparam logic [3:0] S_FINISH   = 4'd10;

  logic [3:0] state;

  logic signed [ELEM_WIDTH-1:0] a_val;
  logic signed [ELEM_WIDTH-1:0] b_val;
  logic                         last_val;

  logic [DOT_W-1:0] dot_sum;
  logic [SQ_W-1:0]  square_sum_a;
  logic [SQ_W-1:0]  square_sum_b;
  logic [CW-1:0]    pair_count;
  logic             too_long;

  logic signed [MW-1:0]   mul_x;
  logic signed [MW-1:0]   mul_y;
  logic signed [2*MW-1:0] prod;

  logic [SQ_W-1:0]   rx;
  logic [DOT_W-1:0]  rr;
  logic [SQ_W-1:0]   rbit;
  logic [DOT_W:0]    rsum;
  logic              rtake;
  logic [SQ_W-1:0]   rx_next;
  logic [DOT_W-1:0]  rr_next;
  logic [ROOT_W-1:0] root_a;
  logic [ROOT_W-1:0] root_b;

  logic [DIV_W-1:0]  rem;
  logic [DIV_W-1:0]  dsh;
  logic [QUOT_W-1:0] quot;
  logic [DCNT_W-1:0] dcnt;
  logic              dtake;
  logic              dovf;

  logic              neg;
  logic [DOT_W-1:0]  mag;
  logic [SIM_W-1:0]  sim_value;
  status_t           stat;

  logic accept;
  logic out_free;

  assign in_ready = (state == S_IDLE) && !rst;
  assign accept = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    unique case (state)
      S_MAC_AB: begin
        mul_x = MW'(a_val);
        mul_y = MW'(b_val);
      end
      S_MAC_AA: begin
        mul_x = MW'(a_val);
        mul_y = MW'(a_val);
      end
      S_MAC_BB: begin
        mul_x = MW'(b_val);
        mul_y = MW'(b_val);
      end
      default: begin
        mul_x = MW'(root_a);
        mul_y = MW'(root_b);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_x * mul_y;
  end

  always_comb begin
    rsum = (DOT_W + 1)'(rr) + (DOT_W + 1)'(rbit);
    rtake = (DOT_W + 1)'(rx) >= rsum;
    rx_next = rtake ? (rx - rsum[SQ_W-1:0]) : rx;
    rr_next = rtake ? ((rr >> 1) + DOT_W'(rbit)) : (rr >> 1);
  end

  assign dtake = rem >= dsh;
  assign neg = dot_sum[DOT_W-1];
  assign mag = neg ? (DOT_W'(0) - dot_sum) : dot_sum;

  // The quotient cannot fit the divide when the magnitude reaches eight times the root product.
  assign dovf = (DOT_W + 3)'(mag) >= {prod[DOT_W-1:0], 3'b000};

  always_comb begin
    if (stat != STAT_OK) begin
      sim_value = '0;
    end else if (neg) begin
      if (quot > QUOT_W'(32768)) begin
        sim_value = SIM_W'(32768);
      end else begin
        sim_value = SIM_W'(QUOT_W'(0) - quot);
      end
    end else begin
      if (quot > QUOT_W'(32767)) begin
        sim_value = SIM_W'(32767);
      end else begin
        sim_value = quot[SIM_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_val <= elem_a;
      b_val <= elem_b;
      last_val <= last;
    end

    unique case (state)
      S_MAC_END: begin
        rx <= square_sum_a;
        rr <= '0;
        rbit <= SQ_W'(1) << (SQ_W - 1);
      end
      S_ROOT_A: begin
        if (rbit[0]) begin
          root_a <= rr_next[ROOT_W-1:0];
          rx <= square_sum_b;
          rr <= '0;
          rbit <= SQ_W'(1) << (SQ_W - 1);
        end else begin
          rx <= rx_next;
          rr <= rr_next;
          rbit <= rbit >> 2;
        end
      end
      S_ROOT_B: begin
        rx <= rx_next;
        rr <= rr_next;
        rbit <= rbit >> 2;
        if (rbit[0]) begin
          root_b <= rr_next[ROOT_W-1:0];
        end
      end
      S_DIV_LOAD: begin
        rem <= DIV_W'({mag, FRAC_W'(0)});
        dsh <= DIV_W'({prod[DOT_W-1:0], (QUOT_W - 1)'(0)});
        dcnt <= DCNT_W'(QUOT_W - 1);
        quot <= {QUOT_W{dovf}};
      end
      S_DIV: begin
        if (dtake) begin
          rem <= rem - dsh;
        end
        quot <= {quot[QUOT_W-2:0], dtake};
        dsh <= dsh >> 1;
        dcnt <= dcnt - 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      dot_sum <= '0;
      square_sum_a <= '0;
      square_sum_b <= '0;
      pair_count <= '0;
      too_long <= 1'b0;
      stat <= STAT_OK;
      out_valid <= 1'b0;
      similarity <= '0;
      status <= STAT_OK;
    end else begin
      if (out_valid && out_ready && state != S_FINISH) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (pair_count < CW'(MAX_LEN)) begin
              pair_count <= pair_count + 1'b1;
              state <= S_MAC_AB;
            end else begin
              too_long <= 1'b1;
              if (last) begin
                stat <= STAT_OVERLENGTH;
                state <= S_FINISH;
              end
            end
          end
        end
        S_MAC_AB: begin
          state <= S_MAC_AA;
        end
        S_MAC_AA: begin
          dot_sum <= dot_sum + prod[DOT_W-1:0];
          state <= S_MAC_BB;
        end
        S_MAC_BB: begin
          square_sum_a <= square_sum_a + prod[SQ_W-1:0];
          state <= S_MAC_END;
        end
        S_MAC_END: begin
          square_sum_b <= square_sum_b + prod[SQ_W-1:0];
          if (last_val) begin
            stat <= STAT_OK;
            state <= S_ROOT_A;
          end else begin
            state <= S_IDLE;
          end
        end
        S_ROOT_A: begin
          if (rbit[0]) begin
            state <= S_ROOT_B;
          end
        end
        S_ROOT_B: begin
          if (rbit[0]) begin
            state <= S_MUL_R;
          end
        end
        S_MUL_R: begin
          state <= S_DIV_LOAD;
        end
        S_DIV_LOAD: begin
          if (root_a == '0 || root_b == '0) begin
            stat <= STAT_ZERO_NORM;
            state <= S_FINISH;
          end else if (dovf) begin
            state <= S_FINISH;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (dcnt == '0) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            out_valid <= 1'b1;
            similarity <= sim_value;
            status <= stat;
            dot_sum <= '0;
            square_sum_a <= '0;
            square_sum_b <= '0;
            pair_count <= '0;
            too_long <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: src/cosim_checker.sv
`include "cosine_similarity_stream_assert.svh"

module cosim_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               last,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [15:0] similarity,
  input cosim_pkg::status_t status
);
  import cosim_pkg::*;

  `COSIM_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(similarity) && $stable(status), "Result changed or dropped while stalled.")
  `COSIM_ASSERT(a_fail_zero, out_valid && status != STAT_OK |-> similarity == 16'sd0, "Failed status carries a nonzero similarity.")
  `COSIM_ASSERT(a_last_busy, in_valid && in_ready && last |=> !in_ready, "Block took a request while closing the vectors.")
  `COSIM_ASSERT_ALWAYS(a_reset_quiet, rst |=> !out_valid, "Result shown right after reset.")

endmodule

bind cosine_similarity_stream cosim_checker u_cosim_checker (.*);
